### src/pkrms_pkg.sv
package pkrms_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W        = 3;
  localparam int SAMPLE_W     = 16;
  localparam int LEVEL_W      = 16;
  localparam int SQ_W         = 2 * SAMPLE_W;
  localparam int ACC_W        = 46;
  localparam int WIN_W        = 17;
  localparam int FRAME_W      = 16;
  localparam int ROOT_W       = ACC_W / 2;
  localparam int SREM_W       = ROOT_W + 2;
  localparam int DS_CNT_W     = $clog2(ACC_W);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 17;

  localparam logic [ACC_W-1:0] ACC_MAX      = {ACC_W{1'b1}};
  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1024);
  localparam logic [WIN_W-1:0] WINDOW_MAX   = WIN_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHANNEL = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LAST_CHANNEL  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MODE          = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_BYTES    = CFG_IDX_W'(5);

  localparam logic MODE_PEAK = 1'b0;
  localparam logic MODE_RMS  = 1'b1;

endpackage

### src/pkrms_divsqrt.sv
module pkrms_divsqrt import pkrms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [ACC_W-1:0]   dividend,
  input  logic [WIN_W-1:0]   divisor,
  output logic               done,
  output logic [LEVEL_W-1:0] root
);

  localparam logic [1:0] DS_IDLE = 2'd0;
  localparam logic [1:0] DS_DIV  = 2'd1;
  localparam logic [1:0] DS_SQRT = 2'd2;

  logic [1:0]          st_r;
  logic [DS_CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0]    q_r;
  logic [WIN_W-1:0]    dvs_r;
  logic [WIN_W-1:0]    drem_r;
  logic [SREM_W-1:0]   srem_r;
  logic [ROOT_W-1:0]   root_r;
  logic                done_r;

  logic [WIN_W:0]      d_trial;
  logic [WIN_W:0]      d_diff;
  logic                d_ge;
  logic [WIN_W-1:0]    drem_nxt;
  logic [SREM_W+1:0]   s_t;
  logic [SREM_W+1:0]   s_trial;
  logic [SREM_W+1:0]   s_diff;
  logic                s_ge;
  logic [SREM_W-1:0]   srem_nxt;

  // Restoring division, one quotient bit per cycle. The quotient is left in
  // q_r, which the square root then consumes two bits per cycle from the top.
  always_comb begin
    d_trial  = {drem_r, q_r[ACC_W-1]};
    d_ge     = d_trial >= {1'b0, dvs_r};
    d_diff   = d_trial - {1'b0, dvs_r};
    drem_nxt = d_ge ? d_diff[WIN_W-1:0] : d_trial[WIN_W-1:0];

    s_t      = {srem_r, q_r[ACC_W-1:ACC_W-2]};
    s_trial  = {(SREM_W+2-ROOT_W-2)'(0), root_r, 2'b01};
    s_ge     = s_t >= s_trial;
    s_diff   = s_t - s_trial;
    srem_nxt = s_ge ? s_diff[SREM_W-1:0] : s_t[SREM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= DS_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        DS_IDLE: begin
          if (start) begin
            q_r    <= dividend;
            dvs_r  <= divisor;
            drem_r <= '0;
            cnt_r  <= DS_CNT_W'(ACC_W - 1);
            st_r   <= DS_DIV;
          end
        end
        DS_DIV: begin
          q_r    <= {q_r[ACC_W-2:0], d_ge};
          drem_r <= drem_nxt;
          if (cnt_r == '0) begin
            cnt_r  <= DS_CNT_W'(ROOT_W - 1);
            srem_r <= '0;
            root_r <= '0;
            st_r   <= DS_SQRT;
          end else begin
            cnt_r <= cnt_r - DS_CNT_W'(1);
          end
        end
        DS_SQRT: begin
          q_r    <= {q_r[ACC_W-3:0], 2'b00};
          srem_r <= srem_nxt;
          root_r <= {root_r[ROOT_W-2:0], s_ge};
          if (cnt_r == '0) begin
            done_r <= 1'b1;
            st_r   <= DS_IDLE;
          end else begin
            cnt_r <= cnt_r - DS_CNT_W'(1);
          end
        end
        default: st_r <= DS_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign root = (|root_r[ROOT_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}} : root_r[LEVEL_W-1:0];

endmodule

### src/multichannel_peak_rms_meter.sv
// Windowed peak / RMS level meter for an interleaved stream of 16-bit samples.
// The per-channel accumulators live in a small synchronous memory; each sample
// is accepted in S_IDLE and then takes one read-modify-write of its channel's
// entry in S_UPD, during which the input is not ready, so the block cannot take
// a new sample before the last one is written. At the end of a window the block
// sweeps the channels in ascending order and is not ready for samples until the
// last level is loaded into the output register. In peak mode each measured
// channel passes S_SWEEP, S_SWREAD and S_LOAD; in RMS mode it also waits in
// S_CALC for the shared divide-then-square-root unit, which divides and then
// takes the square root. Unmeasured channels are skipped in S_SWEEP. Accumulators
// are cleared by per-entry valid bits, so there is no clearing pass after reset or between windows.
module multichannel_peak_rms_meter import pkrms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_channel,
  output logic [LEVEL_W-1:0]    out_level,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPD    = 3'd1;
  localparam logic [2:0] S_SWEEP  = 3'd2;
  localparam logic [2:0] S_SWREAD = 3'd3;
  localparam logic [2:0] S_CALC   = 3'd4;
  localparam logic [2:0] S_LOAD   = 3'd5;

  localparam logic [CH_W-1:0] CH_LAST = CH_W'(MAX_CHANNELS - 1);

  // Configuration registers.
  logic [CNT_W-1:0]  chan_count_r;
  logic [1:0]        first_ch_r;
  logic [1:0]        last_ch_r;
  logic              mode_r;
  logic [WIN_W-1:0]  window_r;
  logic              swap_r;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;
  logic [CH_W-1:0]   pos_r;
  logic [FRAME_W-1:0] fc_r;
  logic [CH_W-1:0]   sw_ch_r;
  logic [LEVEL_W-1:0] mag_r;
  logic [SQ_W-1:0]   sq_r;
  logic [LEVEL_W-1:0] lvl_r;

  logic              out_valid_r;
  logic [1:0]        out_channel_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic              out_last_r;

  // Accumulator memory with one valid bit per entry.
  logic [ACC_W-1:0]  acc_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] acc_vld_r;
  logic [ACC_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic [CH_W-1:0]   rd_addr;
  logic              mem_we;
  logic [ACC_W-1:0]  wr_data;

  logic [CH_W:0]     eff_count;
  logic [WIN_W-1:0]  eff_win;
  logic [MAX_CHANNELS-1:0] meas_mask;
  logic [MAX_CHANNELS-1:0] last_vec;
  logic [SAMPLE_W-1:0] w_sw;
  logic [LEVEL_W-1:0] mag;
  logic              in_xfer;
  logic [ACC_W-1:0]  acc_rd;
  logic [ACC_W:0]    sum;
  logic [ACC_W-1:0]  rms_acc;
  logic [ACC_W-1:0]  peak_acc;
  logic [CH_W:0]     pos_inc;
  logic              frame_end;
  logic [WIN_W-1:0]  fc_inc;
  logic              win_end;
  logic              sw_at_end;
  logic [LEVEL_W-1:0] peak_lvl;

  logic              ds_start;
  logic              ds_done;
  logic [LEVEL_W-1:0] ds_root;
  logic              out_load;
  logic              sweep_end;
  logic              sw_step;

  always_comb begin
    if (chan_count_r == '0) begin
      eff_count = (CH_W+1)'(1);
    end else if (32'(chan_count_r) > MAX_CHANNELS) begin
      eff_count = (CH_W+1)'(MAX_CHANNELS);
    end else begin
      eff_count = (CH_W+1)'(chan_count_r);
    end

    if (window_r == '0) begin
      eff_win = WIN_W'(1);
    end else if (window_r > WINDOW_MAX) begin
      eff_win = WINDOW_MAX;
    end else begin
      eff_win = window_r;
    end

    for (int i = 0; i < MAX_CHANNELS; i++) begin
      meas_mask[i] = (i < 32'(eff_count)) && (i >= 32'(first_ch_r)) && (i <= 32'(last_ch_r));
    end
    // A channel is the last of the window when no measured channel lies above it.
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      last_vec[i] = meas_mask[i] && ((meas_mask >> (i + 1)) == '0);
    end
  end

  // Sample magnitude: optional byte swap, then absolute value of the
  // two's complement word (the most negative value gives 32768).
  always_comb begin
    w_sw = swap_r ? {in_sample_word[7:0], in_sample_word[15:8]} : in_sample_word;
    mag  = w_sw[SAMPLE_W-1] ? LEVEL_W'(17'h10000 - {1'b0, w_sw}) : w_sw;
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    acc_rd    = rd_vld_r ? rd_data_r : '0;
    sum       = {1'b0, acc_rd} + (ACC_W+1)'(sq_r);
    rms_acc   = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    peak_acc  = (ACC_W'(mag_r) > acc_rd) ? ACC_W'(mag_r) : acc_rd;
    peak_lvl  = (|acc_rd[ACC_W-1:LEVEL_W]) ? {LEVEL_W{1'b1}} : acc_rd[LEVEL_W-1:0];
    pos_inc   = {1'b0, pos_r} + (CH_W+1)'(1);
    frame_end = pos_inc >= eff_count;
    fc_inc    = {1'b0, fc_r} + WIN_W'(1);
    win_end   = frame_end && ((fc_inc >= eff_win) || fc_inc[FRAME_W]);
    sw_at_end = (sw_ch_r == CH_LAST);
  end

  assign rd_addr = (state_r == S_IDLE) ? pos_r : sw_ch_r;
  assign mem_we  = (state_r == S_UPD) && meas_mask[pos_r];
  assign wr_data = (mode_r == MODE_RMS) ? rms_acc : peak_acc;

  always_ff @(posedge clk) begin
    rd_data_r <= acc_mem[rd_addr];
    rd_vld_r  <= acc_vld_r[rd_addr];
    if (mem_we) begin
      acc_mem[pos_r] <= wr_data;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ds_start  = 1'b0;
    out_load  = 1'b0;
    sweep_end = 1'b0;
    sw_step   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = win_end ? S_SWEEP : S_IDLE;
      end
      S_SWEEP: begin
        if (meas_mask[sw_ch_r]) begin
          state_nxt = S_SWREAD;
        end else if (sw_at_end) begin
          sweep_end = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          sw_step = 1'b1;
        end
      end
      S_SWREAD: begin
        if (mode_r == MODE_RMS) begin
          ds_start  = 1'b1;
          state_nxt = S_CALC;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_CALC: begin
        if (ds_done) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (last_vec[sw_ch_r] || sw_at_end) begin
            sweep_end = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            sw_step   = 1'b1;
            state_nxt = S_SWEEP;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= CNT_W'(1);
      first_ch_r   <= '0;
      last_ch_r    <= '0;
      mode_r       <= MODE_PEAK;
      window_r     <= WINDOW_RESET;
      swap_r       <= 1'b0;
      state_r      <= S_IDLE;
      pos_r        <= '0;
      fc_r         <= '0;
      sw_ch_r      <= '0;
      acc_vld_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: chan_count_r <= cfg_wdata[CNT_W-1:0];
          REG_FIRST_CHANNEL: first_ch_r   <= cfg_wdata[1:0];
          REG_LAST_CHANNEL:  last_ch_r    <= cfg_wdata[1:0];
          REG_MODE:          mode_r       <= cfg_wdata[0];
          REG_WINDOW_FRAMES: window_r     <= cfg_wdata[WIN_W-1:0];
          REG_SWAP_BYTES:    swap_r       <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (state_r == S_UPD) begin
        if (frame_end) begin
          pos_r <= '0;
          fc_r  <= win_end ? '0 : fc_inc[FRAME_W-1:0];
        end else begin
          pos_r <= pos_inc[CH_W-1:0];
        end
        if (win_end) begin
          sw_ch_r <= '0;
        end
      end

      if (mem_we) begin
        acc_vld_r[pos_r] <= 1'b1;
      end
      // Every entry, measured or not, starts the next window at zero.
      if (sweep_end) begin
        acc_vld_r <= '0;
      end
      if (sw_step) begin
        sw_ch_r <= sw_ch_r + CH_W'(1);
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag_r <= mag;
      sq_r  <= SQ_W'(mag) * SQ_W'(mag);
    end
    if (state_r == S_SWREAD) begin
      lvl_r <= peak_lvl;
    end else if (state_r == S_CALC && ds_done) begin
      lvl_r <= ds_root;
    end
    if (out_load) begin
      out_channel_r <= 2'(sw_ch_r);
      out_level_r   <= lvl_r;
      out_last_r    <= last_vec[sw_ch_r] || sw_at_end;
    end
  end

  pkrms_divsqrt u_divsqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ds_start),
    .dividend (acc_rd),
    .divisor  (eff_win),
    .done     (ds_done),
    .root     (ds_root)
  );

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_level   = out_level_r;
  assign out_last    = out_last_r;

endmodule

### src/pkrms_checker.sv
module pkrms_checker import pkrms_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_channel,
  input logic [LEVEL_W-1:0] out_level,
  input logic               out_last
);

  // A result that is not taken holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(out_level)
                                && $stable(out_last))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Each sample transfer is followed by its memory update cycle.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready during accumulator update");

  // While a window's levels are still being delivered, no sample is taken.
  a_sweep_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a window report");

endmodule

bind multichannel_peak_rms_meter pkrms_checker u_pkrms_checker (.*);
